// ----- hw/rtl/blake3_stream_hasher_unit_macros.svh -----
// Assertion macros for the BLAKE3 stream hasher
`ifndef BLAKE3_STREAM_HASHER_UNIT_MACROS_SVH
`define BLAKE3_STREAM_HASHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define B3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define B3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define B3_ASSERT_IMPL(label, clk, rst, ante, cons)
`define B3_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/b3sh_pkg.sv -----
package b3sh_pkg;

   localparam logic [31:0] IV_0 = 32'h6A09E667;
   localparam logic [31:0] IV_1 = 32'hBB67AE85;
   localparam logic [31:0] IV_2 = 32'h3C6EF372;
   localparam logic [31:0] IV_3 = 32'hA54FF53A;
   localparam logic [31:0] IV_4 = 32'h510E527F;
   localparam logic [31:0] IV_5 = 32'h9B05688C;
   localparam logic [31:0] IV_6 = 32'h1F83D9AB;
   localparam logic [31:0] IV_7 = 32'h5BE0CD19;

   localparam logic [3:0] FLAG_CHUNK_START = 4'b0001;
   localparam logic [3:0] FLAG_CHUNK_END   = 4'b0010;
   localparam logic [3:0] FLAG_PARENT      = 4'b0100;
   localparam logic [3:0] FLAG_ROOT        = 4'b1000;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] cv_type;
   typedef word_type [15:0] blk_type;

   // compression input source for the chaining value and block
   typedef enum logic [1:0] {
      SRC_CHUNK  = 2'd0,  // chunk cv, block buffer, chunk counter
      SRC_PARENT = 2'd1,  // IV, {stack entry, last result}
      SRC_FINAL  = 2'd2   // held node (final fold)
   } src_type;

   // controller -> datapath commands
   typedef struct packed {
      logic       absorb;        // write current byte into block buffer
      logic [2:0] byte_sel;      // which input byte
      logic       load_item;     // latch input item
      logic       comp_start;    // start a compression
      src_type    src;
      logic [3:0] flags;
      logic       len64;         // length 64 instead of fill
      logic       ctr_zero;      // counter zero
      logic       cv_update;     // chunk cv <= result (block done)
      logic       clear_block;   // clear buffer and fill
      logic       open_next;     // reset chunk state, count + 1
      logic       open_zero;     // reset chunk state, count 0
      logic       stack_rd;      // read stack at height-1
      logic       pop;           // height - 1
      logic       push;          // write result cv, height + 1
      logic       node_save;     // held node <= parent node from stack+result
      logic       node_chunk;    // held node <= open chunk
      logic       total_shift;   // merge count >> 1
      logic       total_load;    // merge count <= chunk count + 1
      logic       h_load;        // fold height <= stack height
      logic       h_dec;
      logic       out_load;      // digest word register load
      logic [1:0] out_idx;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic [3:0] cnt;
      logic       eom;
      logic       fill_full;     // block fill == 64
      logic       last_block;    // blocks done >= 15
      logic       comp_done;
      logic       merge_more;    // merge count nonzero and even
      logic       fold_more;     // fold height > 0
   } stat_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [3:0] perm_idx(input logic [3:0] i);
      case (i)
         4'd0: perm_idx = 4'd2;   4'd1: perm_idx = 4'd6;
         4'd2: perm_idx = 4'd3;   4'd3: perm_idx = 4'd10;
         4'd4: perm_idx = 4'd7;   4'd5: perm_idx = 4'd0;
         4'd6: perm_idx = 4'd4;   4'd7: perm_idx = 4'd13;
         4'd8: perm_idx = 4'd1;   4'd9: perm_idx = 4'd11;
         4'd10: perm_idx = 4'd12; 4'd11: perm_idx = 4'd5;
         4'd12: perm_idx = 4'd9;  4'd13: perm_idx = 4'd14;
         4'd14: perm_idx = 4'd15; default: perm_idx = 4'd8;
      endcase
   endfunction

endpackage

// ----- hw/rtl/blake3_stream_hasher_unit.sv -----
// BLAKE3 stream hasher (unkeyed, 256-bit digest).
// Input channel req_: up to eight message bytes per item (req_data_bytes,
// first byte in bits 7:0), req_byte_count valid bytes (above eight counts as
// eight), req_end_of_message on the last item. An empty message is an item
// with zero bytes and the end mark.
// Result channel rsp_: four items per message, rsp_hash_word with
// rsp_word_index 0..3, rsp_last_word on the fourth.
// One item at a time: each byte is absorbed in turn; a byte that follows a
// full block first waits for that block's compression (one half-round a
// cycle), a chunk close waits for the chunk's compression, then for one
// compression per merge, and then pushes the result.
// The end mark adds one compression per stack level plus one for the root,
// then loads and offers each digest word in turn while rsp_stall is low.
// req_stall stays high while an item is being worked on. A high rsp_stall
// holds the current digest word and the whole block.
// Synchronous reset returns to an empty message with an empty stack; after
// the last digest word the block resets the same way for the next message.
module blake3_stream_hasher_unit
   import b3sh_pkg::*;
#(
   parameter int STACK_DEPTH = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_bytes,
   input  logic [3:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

`include "blake3_stream_hasher_unit_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   b3sh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word), .stat(stat), .cmd(cmd)
   );

   b3sh_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .in_data(req_data_bytes),
      .in_count(req_byte_count), .in_eom(req_end_of_message), .cmd(cmd),
      .stat(stat), .out_word(rsp_hash_word)
   );

   // no input is taken while a digest is pending
   `B3_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_valid, req_stall)
   // a stalled digest word keeps its index
   `B3_ASSERT_NEXT(a_idx_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_word_index == $past(rsp_word_index))
   // compression never starts while a push or absorb is issued
   `B3_ASSERT_IMPL(a_cmd_excl, clock, reset, cmd.comp_start, !cmd.absorb && !cmd.push)

endmodule

// ----- hw/rtl/b3sh_compress.sv -----
// Iterative compression: one half-round (four mixes) per cycle
module b3sh_compress
   import b3sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  cv_type      cv,
   input  blk_type     blk,
   input  logic [63:0] ctr,
   input  logic [6:0]  len,
   input  logic [3:0]  flags,
   output logic        done,
   output cv_type      res
);

   logic [15:0][31:0] v_ff, v_in;
   blk_type m_ff, m_in;
   cv_type  cv_ff;
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;

   function automatic logic [3:0][31:0] g(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d,
                                          input logic [31:0] x, input logic [31:0] y);
      logic [31:0] ta, tb, tc, td;
      ta = a + b + x;
      td = rotr(d ^ ta, 16);
      tc = c + td;
      tb = rotr(b ^ tc, 12);
      ta = ta + tb + y;
      td = rotr(td ^ ta, 8);
      tc = tc + td;
      tb = rotr(tb ^ tc, 7);
      g = {td, tc, tb, ta};
   endfunction

   // one half-round of mixing, message permuted after the diagonal half
   always_comb begin
      logic [3:0][31:0] r;
      r = '0;
      v_in = v_ff;
      m_in = m_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in = {flags == 4'd0 ? 32'd0 : {28'd0, flags}, 25'd0, len, ctr[63:32],
                 ctr[31:0], IV_3, IV_2, IV_1, IV_0, cv[7], cv[6], cv[5], cv[4],
                 cv[3], cv[2], cv[1], cv[0]};
         m_in = blk;
         step_in = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!step_ff[0]) begin
            for (int i = 0; i < 4; i++) begin
               r = g(v_ff[i], v_ff[4+i], v_ff[8+i], v_ff[12+i], m_ff[2*i], m_ff[2*i+1]);
               v_in[i] = r[0]; v_in[4+i] = r[1]; v_in[8+i] = r[2]; v_in[12+i] = r[3];
            end
         end else begin
            for (int i = 0; i < 4; i++) begin
               r = g(v_ff[i], v_ff[4+((i+1)%4)], v_ff[8+((i+2)%4)], v_ff[12+((i+3)%4)],
                     m_ff[8+2*i], m_ff[9+2*i]);
               v_in[i] = r[0]; v_in[4+((i+1)%4)] = r[1];
               v_in[8+((i+2)%4)] = r[2]; v_in[12+((i+3)%4)] = r[3];
            end
            for (int i = 0; i < 16; i++) m_in[i] = m_ff[perm_idx(4'(i))];
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd13) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      v_ff <= v_in;
      m_ff <= m_in;
      if (start) cv_ff <= cv;
   end

   // output words 0..7 are the chaining value; digest takes them too
   always_comb begin
      for (int i = 0; i < 8; i++) res[i] = v_ff[i] ^ v_ff[8+i];
   end
   assign done = done_ff;

   logic unused_cv;
   assign unused_cv = ^cv_ff;

endmodule

// ----- hw/rtl/b3sh_datapath.sv -----
// Datapath: item latch, block buffer, chunk state, subtree stack, compressor
module b3sh_datapath
   import b3sh_pkg::*;
#(
   parameter int STACK_DEPTH = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] in_data,
   input  logic [3:0]  in_count,
   input  logic        in_eom,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [63:0] out_word
);

   localparam int HW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [63:0] data_ff;
   logic [3:0]  cnt_ff;
   logic        eom_ff;
   cv_type      ccv_ff;
   blk_type     buf_ff;
   logic [6:0]  fill_ff;
   logic [4:0]  bdone_ff;
   logic [63:0] ccount_ff;
   logic [HW-1:0] height_ff;
   logic [63:0] total_ff;
   logic [HW-1:0] fold_ff;
   cv_type      stk_rd_ff;
   cv_type      mem [STACK_DEPTH];
   // held node for final fold
   cv_type      ncv_ff;
   blk_type     nblk_ff;
   logic [63:0] nctr_ff;
   logic [6:0]  nlen_ff;
   logic [3:0]  nflags_ff;
   logic [63:0] out_ff;

   cv_type      c_cv, c_res;
   blk_type     c_blk;
   logic [63:0] c_ctr;
   logic [6:0]  c_len;
   logic [3:0]  c_flags;
   logic        c_done;
   cv_type      iv;
   logic [7:0]  cur_byte;

   assign iv = {IV_7, IV_6, IV_5, IV_4, IV_3, IV_2, IV_1, IV_0};
   assign cur_byte = data_ff[8*cmd.byte_sel +: 8];

   // compressor operand selection
   always_comb begin
      c_cv = ccv_ff; c_blk = buf_ff; c_ctr = ccount_ff;
      c_len = cmd.len64 ? 7'd64 : fill_ff;
      c_flags = cmd.flags | ((bdone_ff == 5'd0 && cmd.src == SRC_CHUNK) ?
                             FLAG_CHUNK_START : 4'd0);
      case (cmd.src)
         SRC_PARENT: begin
            c_cv = iv; c_blk = {c_res, stk_rd_ff}; c_ctr = 64'd0; c_len = 7'd64;
         end
         SRC_FINAL: begin
            c_cv = ncv_ff; c_blk = nblk_ff; c_ctr = cmd.ctr_zero ? 64'd0 : nctr_ff;
            c_len = nlen_ff;
            c_flags = nflags_ff | cmd.flags;
         end
         default: ;
      endcase
   end

   b3sh_compress u_comp (
      .clock(clock), .reset(reset), .start(cmd.comp_start), .cv(c_cv), .blk(c_blk),
      .ctr(c_ctr), .len(c_len), .flags(c_flags), .done(c_done), .res(c_res)
   );

   // stack memory
   always_ff @(posedge clock) begin
      if (cmd.push && height_ff < HW'(STACK_DEPTH)) mem[height_ff[AW-1:0]] <= c_res;
      if (cmd.stack_rd) begin
         if (height_ff != '0 && height_ff <= HW'(STACK_DEPTH))
            stk_rd_ff <= mem[AW'(height_ff - HW'(1))];
         else stk_rd_ff <= '0;
      end
      if (cmd.h_dec && fold_ff != '0) stk_rd_ff <= mem[AW'(fold_ff - HW'(1))];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         data_ff <= in_data;
         cnt_ff <= (in_count > 4'd8) ? 4'd8 : in_count;
         eom_ff <= in_eom;
      end
      if (cmd.out_load) out_ff <= {c_res[2*cmd.out_idx+1], c_res[2*cmd.out_idx]};
      if (cmd.node_chunk) begin
         ncv_ff <= ccv_ff; nblk_ff <= buf_ff; nctr_ff <= ccount_ff; nlen_ff <= fill_ff;
         nflags_ff <= FLAG_CHUNK_END | ((bdone_ff == 5'd0) ? FLAG_CHUNK_START : 4'd0);
      end
      if (cmd.node_save) begin
         ncv_ff <= iv; nblk_ff <= {c_res, stk_rd_ff}; nctr_ff <= 64'd0;
         nlen_ff <= 7'd64; nflags_ff <= FLAG_PARENT;
      end
      if (cmd.total_load) total_ff <= ccount_ff + 64'd1;
      else if (cmd.total_shift) total_ff <= total_ff >> 1;
   end

   // chunk state
   always_ff @(posedge clock) begin
      if (reset) begin
         ccv_ff <= iv; buf_ff <= '0; fill_ff <= '0; bdone_ff <= '0;
         ccount_ff <= '0; height_ff <= '0; fold_ff <= '0;
      end else begin
         if (cmd.cv_update) begin
            ccv_ff <= c_res;
            bdone_ff <= bdone_ff + 5'd1;
         end
         if (cmd.clear_block) begin
            buf_ff <= '0; fill_ff <= '0;
         end else if (cmd.absorb) begin
            buf_ff[fill_ff[5:2]][8*fill_ff[1:0] +: 8] <= cur_byte;
            fill_ff <= fill_ff + 7'd1;
         end
         if (cmd.open_next || cmd.open_zero) begin
            ccv_ff <= iv; buf_ff <= '0; fill_ff <= '0; bdone_ff <= '0;
            ccount_ff <= cmd.open_zero ? 64'd0 : ccount_ff + 64'd1;
         end
         if (cmd.pop && height_ff != '0 && height_ff <= HW'(STACK_DEPTH))
            height_ff <= height_ff - HW'(1);
         if (cmd.push && height_ff < HW'(STACK_DEPTH)) height_ff <= height_ff + HW'(1);
         if (cmd.open_zero) height_ff <= '0;
         if (cmd.h_load) fold_ff <= (height_ff > HW'(STACK_DEPTH)) ? HW'(STACK_DEPTH)
                                                                     : height_ff;
         else if (cmd.h_dec && fold_ff != '0) fold_ff <= fold_ff - HW'(1);
      end
   end

   assign stat.cnt = cnt_ff;
   assign stat.eom = eom_ff;
   assign stat.fill_full = fill_ff[6];
   assign stat.last_block = bdone_ff >= 5'd15;
   assign stat.comp_done = c_done;
   assign stat.merge_more = (total_ff != '0) && !total_ff[0];
   assign stat.fold_more = fold_ff != '0;
   assign out_word = out_ff;

endmodule

// ----- hw/rtl/b3sh_ctrl.sv -----
// Controller: byte sequencing, block/chunk close, merge and fold, digest output
module b3sh_ctrl
   import b3sh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic [1:0] rsp_word_index,
   output logic     rsp_last_word,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_BYTE, S_BLK_WAIT, S_CLOSE_WAIT, S_MERGE_RD, S_MERGE_WAIT,
      S_PUSH, S_FOLD_START, S_FOLD_WAIT, S_FOLD_RD, S_ROOT_WAIT, S_OUT_LOAD, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] bi_ff;
   logic [1:0] oi_ff;
   logic rv_ff;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rv_ff;
   assign rsp_word_index = oi_ff;
   assign rsp_last_word = oi_ff == 2'd3;

   // command decode from state
   always_comb begin
      cmd = '0;
      cmd.byte_sel = bi_ff[2:0];
      cmd.out_idx = oi_ff;
      cmd.src = SRC_CHUNK;
      unique case (state_ff)
         S_IDLE: cmd.load_item = req_valid;
         S_BYTE: begin
            if (bi_ff < stat.cnt) begin
               if (stat.fill_full) begin
                  cmd.comp_start = 1'b1;
                  cmd.len64 = !stat.last_block;
                  cmd.flags = stat.last_block ? FLAG_CHUNK_END : 4'd0;
                  cmd.total_load = stat.last_block;
               end else cmd.absorb = 1'b1;
            end else if (stat.eom) begin
               cmd.node_chunk = 1'b1;
               cmd.h_load = 1'b1;
            end
         end
         S_BLK_WAIT: if (stat.comp_done) begin
            cmd.cv_update = 1'b1; cmd.clear_block = 1'b1;
         end
         S_CLOSE_WAIT: if (stat.comp_done) begin
            if (stat.merge_more) cmd.stack_rd = 1'b1;
            else cmd.push = 1'b1;
         end
         S_MERGE_RD: begin
            cmd.pop = 1'b1; cmd.comp_start = 1'b1; cmd.src = SRC_PARENT;
            cmd.flags = FLAG_PARENT; cmd.total_shift = 1'b1;
         end
         S_MERGE_WAIT: if (stat.comp_done) begin
            if (stat.merge_more) cmd.stack_rd = 1'b1;
            else cmd.push = 1'b1;
         end
         S_PUSH: cmd.open_next = 1'b1;
         S_FOLD_START: begin
            if (stat.fold_more) cmd.h_dec = 1'b1;
            else begin
               // root node: counter zero, ROOT flag
               cmd.comp_start = 1'b1;
               cmd.flags = FLAG_ROOT;
               cmd.ctr_zero = 1'b1;
            end
            cmd.src = SRC_FINAL;
         end
         S_FOLD_RD: begin
            cmd.comp_start = 1'b1; cmd.src = SRC_FINAL;
         end
         S_FOLD_WAIT: begin
            cmd.src = SRC_FINAL;
            if (stat.comp_done) cmd.node_save = 1'b1;
         end
         S_ROOT_WAIT: cmd.src = SRC_FINAL;
         S_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.src = SRC_FINAL;
         end
         S_OUT: begin
            cmd.src = SRC_FINAL;
            if (!rsp_stall && oi_ff == 2'd3) cmd.open_zero = 1'b1;
         end
         default: ;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; bi_ff <= '0; oi_ff <= '0; rv_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               state_ff <= S_BYTE; bi_ff <= '0;
            end
            S_BYTE: begin
               if (bi_ff < stat.cnt) begin
                  if (stat.fill_full)
                     state_ff <= stat.last_block ? S_CLOSE_WAIT : S_BLK_WAIT;
                  else bi_ff <= bi_ff + 4'd1;
               end else state_ff <= stat.eom ? S_FOLD_START : S_IDLE;
            end
            S_BLK_WAIT: if (stat.comp_done) state_ff <= S_BYTE;
            S_CLOSE_WAIT, S_MERGE_WAIT: if (stat.comp_done)
               state_ff <= stat.merge_more ? S_MERGE_RD : S_PUSH;
            S_MERGE_RD: state_ff <= S_MERGE_WAIT;
            S_PUSH: state_ff <= S_BYTE;
            S_FOLD_START: state_ff <= stat.fold_more ? S_FOLD_RD : S_ROOT_WAIT;
            S_FOLD_RD: state_ff <= S_FOLD_WAIT;
            S_FOLD_WAIT: if (stat.comp_done) state_ff <= S_FOLD_START;
            S_ROOT_WAIT: if (stat.comp_done) begin
               state_ff <= S_OUT_LOAD; oi_ff <= '0;
            end
            S_OUT_LOAD: begin
               state_ff <= S_OUT; rv_ff <= 1'b1;
            end
            S_OUT: if (!rsp_stall) begin
               rv_ff <= 1'b0;
               oi_ff <= oi_ff + 2'd1;
               state_ff <= (oi_ff == 2'd3) ? S_IDLE : S_OUT_LOAD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- test/blake3_digest_checker.sv -----
module blake3_digest_checker
   import b3sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_data_bytes,
   input  logic [3:0]  req_byte_count,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_hash_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          words_pending,
   output int          digests_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_LEVELS = 54;

   typedef struct packed {
      logic [63:0] hash_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_word_type;

   // running hash state
   cv_type      open_cv;
   blk_type     blk_buf;
   int unsigned fill;
   int unsigned blocks_done;
   logic [63:0] chunk_ctr;
   cv_type      subtree_cvs [STACK_LEVELS];
   int unsigned depth;

   digest_word_type expected_words[$];

   function automatic cv_type iv_cv();
      cv_type c;
      c[0] = IV_0; c[1] = IV_1; c[2] = IV_2; c[3] = IV_3;
      c[4] = IV_4; c[5] = IV_5; c[6] = IV_6; c[7] = IV_7;
      return c;
   endfunction

   function automatic word_type ror32(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic blk_type blake3_compress(cv_type cv, blk_type m_in, logic [63:0] ctr,
                                              logic [31:0] len, logic [31:0] flags);
      word_type v[16];
      word_type m[16];
      word_type t[16];
      blk_type  r;
      cv_type   iv;
      int       ai[8], bi[8], ci[8], di[8];
      int       a, b, c, d;
      iv = iv_cv();
      ai = '{0, 1, 2, 3, 0, 1, 2, 3};
      bi = '{4, 5, 6, 7, 5, 6, 7, 4};
      ci = '{8, 9, 10, 11, 10, 11, 8, 9};
      di = '{12, 13, 14, 15, 15, 12, 13, 14};
      for (int i = 0; i < 8; i++) v[i] = cv[i];
      for (int i = 0; i < 4; i++) v[8 + i] = iv[i];
      v[12] = ctr[31:0];
      v[13] = ctr[63:32];
      v[14] = len;
      v[15] = flags;
      for (int i = 0; i < 16; i++) m[i] = m_in[i];
      for (int rd = 0; rd < 7; rd++) begin
         for (int g = 0; g < 8; g++) begin
            a = ai[g]; b = bi[g]; c = ci[g]; d = di[g];
            v[a] = v[a] + v[b] + m[2 * g];
            v[d] = ror32(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = ror32(v[b] ^ v[c], 12);
            v[a] = v[a] + v[b] + m[2 * g + 1];
            v[d] = ror32(v[d] ^ v[a], 8);
            v[c] = v[c] + v[d];
            v[b] = ror32(v[b] ^ v[c], 7);
         end
         // message schedule permutation
         t = '{m[2], m[6], m[3], m[10], m[7], m[0], m[4], m[13],
               m[1], m[11], m[12], m[5], m[9], m[14], m[15], m[8]};
         m = t;
      end
      for (int i = 0; i < 8; i++) begin
         r[i] = v[i] ^ v[i + 8];
         r[i + 8] = v[i + 8] ^ cv[i];
      end
      return r;
   endfunction

   function automatic logic [31:0] chunk_start_flag();
      return (blocks_done == 0) ? 32'(FLAG_CHUNK_START) : 32'd0;
   endfunction

   function automatic cv_type upper_cv(blk_type r);
      cv_type c;
      for (int i = 0; i < 8; i++) c[i] = r[i];
      return c;
   endfunction

   function automatic blk_type pair_block(cv_type left, cv_type right);
      blk_type b;
      for (int i = 0; i < 8; i++) begin
         b[i] = left[i];
         b[i + 8] = right[i];
      end
      return b;
   endfunction

   function automatic void start_chunk(logic [63:0] ctr);
      open_cv = iv_cv();
      blk_buf = '0;
      fill = 0;
      blocks_done = 0;
      chunk_ctr = ctr;
   endfunction

   // finish a chunk, merge by trailing zeros of the new count, push
   function automatic void retire_chunk();
      logic [63:0] total;
      cv_type      cv, left;
      total = chunk_ctr + 64'd1;
      cv = upper_cv(blake3_compress(open_cv, blk_buf, chunk_ctr, fill,
                                    chunk_start_flag() | 32'(FLAG_CHUNK_END)));
      while (total != 0 && total[0] == 1'b0) begin
         if (depth > 0) begin
            depth--;
            left = subtree_cvs[depth];
         end else begin
            left = '0;
         end
         cv = upper_cv(blake3_compress(iv_cv(), pair_block(left, cv), 64'd0, 32'd64,
                                       32'(FLAG_PARENT)));
         total = total >> 1;
      end
      if (depth < STACK_LEVELS) begin
         subtree_cvs[depth] = cv;
         depth++;
      end
      start_chunk(chunk_ctr + 64'd1);
   endfunction

   function automatic void take_byte(logic [7:0] b);
      if (fill >= 64) begin
         if (blocks_done >= 15) begin
            retire_chunk();
         end else begin
            open_cv = upper_cv(blake3_compress(open_cv, blk_buf, chunk_ctr, 32'd64,
                                               chunk_start_flag()));
            blocks_done++;
            blk_buf = '0;
            fill = 0;
         end
      end
      blk_buf[fill / 4][8 * (fill % 4) +: 8] = b;
      fill++;
   endfunction

   // fold the open chunk up the stack and queue the four digest words
   function automatic void finish_message();
      cv_type      ncv;
      blk_type     blk, r;
      logic [63:0] ctr;
      logic [31:0] len, flags;
      int          h;
      digest_word_type w;
      ncv = open_cv;
      blk = blk_buf;
      ctr = chunk_ctr;
      len = fill;
      flags = chunk_start_flag() | 32'(FLAG_CHUNK_END);
      h = depth;
      while (h > 0) begin
         h--;
         r = blake3_compress(ncv, blk, ctr, len, flags);
         blk = pair_block(subtree_cvs[h], upper_cv(r));
         ncv = iv_cv();
         ctr = 0;
         len = 64;
         flags = 32'(FLAG_PARENT);
      end
      r = blake3_compress(ncv, blk, 64'd0, len, flags | 32'(FLAG_ROOT));
      for (int k = 0; k < 4; k++) begin
         w.hash_word = {r[2 * k + 1], r[2 * k]};
         w.word_index = 2'(k);
         w.last_word = (k == 3);
         expected_words.push_back(w);
      end
      start_chunk(64'd0);
      depth = 0;
   endfunction

   function automatic void predict_item(logic [63:0] data, logic [3:0] cnt, logic eom);
      int n;
      n = (cnt > 8) ? 8 : int'(cnt);
      for (int i = 0; i < n; i++) take_byte(data[8 * i +: 8]);
      if (eom) finish_message();
   endfunction

   assign words_pending = expected_words.size();

   always @(posedge clock) begin
      digest_word_type e;
      if (reset) begin
         start_chunk(64'd0);
         depth = 0;
         expected_words.delete();
         fail_count <= 0;
         digests_seen <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_item(req_data_bytes, req_byte_count, req_end_of_message);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%t: unexpected digest word %h idx %0d", $realtime,
                        rsp_hash_word, rsp_word_index);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_words.pop_front();
               if (rsp_hash_word !== e.hash_word || rsp_word_index !== e.word_index ||
                   rsp_last_word !== e.last_word) begin
                  $display("%t: digest word mismatch exp %h/%0d/%0d got %h/%0d/%0d",
                           $realtime, e.hash_word, e.word_index, e.last_word,
                           rsp_hash_word, rsp_word_index, rsp_last_word);
                  fail_count <= fail_count + 1;
               end
               if (e.last_word) digests_seen <= digests_seen + 1;
            end
         end
      end
   end
endmodule

// ----- test/tb_blake3_stream_hasher_unit.sv -----
module tb_blake3_stream_hasher_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_bytes;
   logic [3:0]  req_byte_count;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_hash_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count;
   int          words_pending;
   int          digests_seen;
   int          items_sent;
   int          idle_cycles;
   bit          hold_rsp;
   bit          hold_done;
   bit          stim_done;

   blake3_stream_hasher_unit u_top (.*);

   blake3_digest_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // send one item, after a random gap first when gaps is set
   task automatic send_item(logic [63:0] data, logic [3:0] cnt, logic eom, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_bytes <= data;
      req_byte_count <= cnt;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic end_send();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // receiver stall: random per item outside digests 4..20, or a long hold when asked
   initial begin
      int w;
      rsp_stall = 1'b1;
      hold_done = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end
         w = (digests_seen < 4 || digests_seen > 20) ? $urandom_range(0, 8) : 0;
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog on acceptance activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (hold_rsp && !hold_done))
         idle_cycles <= 0;
      else if (!stim_done || words_pending > 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data_bytes = '0;
      req_byte_count = '0;
      req_end_of_message = 1'b0;
      items_sent = 0;
      hold_rsp = 1'b0;
      stim_done = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extremes, oversize counts, zero-byte no-op
      send_item('0, 4'd0, 1'b1, 1'b0);
      send_item('1, 4'd8, 1'b1, 1'b0);
      send_item('0, 4'd8, 1'b0, 1'b1);
      send_item('1, 4'd15, 1'b0, 1'b1);
      send_item(64'hA5A5_5A5A_F0F0_0F0F, 4'd0, 1'b0, 1'b1);
      send_item(64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b1);
      send_item(64'h8000_0000_0000_0001, 4'd1, 1'b1, 1'b1);
      for (int i = 0; i < 8; i++) send_item(rand64(), 4'd8, 1'b0, 1'b1);
      send_item('0, 4'd0, 1'b1, 1'b1);   // exactly one full block, then end
      send_item(rand64(), 4'd7, 1'b1, 1'b1);

      // sender pause until every digest word has come
      end_send();
      while (words_pending > 0) @(posedge clock);

      // one full chunk, then a short tail that closes it
      for (int i = 0; i < 128; i++) send_item(rand64(), 4'd8, 1'b0, i % 5 == 0);
      send_item(rand64(), 4'($urandom_range(1, 8)), 1'b1, 1'b0);

      // long receiver hold while short messages keep coming
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) send_item(rand64(), 4'($urandom_range(1, 8)), 1'b1, 1'b0);

      // random short messages with noise
      for (int m = 0; m < 4; m++) begin
         for (int i = $urandom_range(0, 2); i > 0; i--)
            send_item(rand64(), 4'($urandom_range(0, 15)), 1'b0, 1'b1);
         send_item(rand64(), 4'($urandom_range(0, 15)), 1'b1, 1'b1);
      end
      end_send();
      stim_done = 1'b1;

      while (words_pending > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d items in %0d digests: empty, block edge, chunk close and fold,",
               items_sent, digests_seen);
      $display("saturated byte counts, idle no-ops, long result back-pressure.");
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
